>>> src/gfalu_pkg.sv
package gfalu_pkg;

  // Default extension degree m of the field.
  localparam int FIELD_DEGREE_DEF = 67;

  // Fixed widths of the operand and count fields on the ports.
  localparam int LOW_W  = 64;
  localparam int HIGH_W = 3;
  localparam int CNT_W  = 16;

  // Bits of the multiplier operand consumed per cycle.
  localparam int DIGIT_W = 8;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_MUL  = 3'd1,
    OP_SQR  = 3'd2,
    OP_POW  = 3'd3,
    OP_ROOT = 3'd4,
    OP_INV  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_MUL,
    ST_OUT
  } state_t;

  // Handshake between the sequencer and the shared multiplier.
  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

>>> src/gfalu_mul.sv
module gfalu_mul #(
  parameter int FIELD_DEGREE = gfalu_pkg::FIELD_DEGREE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gfalu_pkg::mul_ctl_t         ctl,
  output gfalu_pkg::mul_sts_t         sts,
  input  logic [FIELD_DEGREE-1:0]     op_x,
  input  logic [FIELD_DEGREE-1:0]     op_y,
  input  logic [gfalu_pkg::LOW_W-1:0] poly,
  output logic [FIELD_DEGREE-1:0]     product
);
  import gfalu_pkg::*;

  localparam int NDIG  = (FIELD_DEGREE + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W = NDIG * DIGIT_W;
  localparam int DC_W  = $clog2(NDIG + 1);

  logic [FIELD_DEGREE-1:0] acc_r, acc_nxt;
  logic [PAD_W-1:0]        x_r, x_nxt;
  logic [FIELD_DEGREE-1:0] y_r, y_nxt;
  logic [DC_W-1:0]         cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;

  // Multiply by x and fold the overflowing top term back in.
  function automatic logic [FIELD_DEGREE-1:0] times_x(
    input logic [FIELD_DEGREE-1:0] e,
    input logic [LOW_W-1:0]        p
  );
    logic [FIELD_DEGREE-1:0] s;
    s = {e[FIELD_DEGREE-2:0], 1'b0};
    if (e[FIELD_DEGREE-1]) begin
      s = s ^ {{(FIELD_DEGREE-LOW_W){1'b0}}, p};
    end
    return s;
  endfunction

  always_comb begin
    logic [FIELD_DEGREE-1:0] t;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    t        = acc_r;
    if (ctl.start && !busy_r) begin
      acc_nxt  = '0;
      x_nxt    = {{(PAD_W-FIELD_DEGREE){1'b0}}, op_x};
      y_nxt    = op_y;
      cnt_nxt  = DC_W'(NDIG);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // One digit of the first operand, most significant bit first.
      for (int d = 0; d < DIGIT_W; d++) begin
        t = times_x(t, poly);
        if (x_r[PAD_W-1-d]) begin
          t = t ^ y_r;
        end
      end
      acc_nxt = t;
      x_nxt   = x_r << DIGIT_W;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DC_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = acc_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start && !busy_r |=> busy_r)
    else $error("multiplier did not start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("multiplier done while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("multiplier done without work");

endmodule

>>> src/gf2m_field_alu.sv
// Add, the inverse of zero and unused opcodes need no product; multiply and square take one
// product each. Power and root run a chain of squarings of the operand, and inverse takes
// 2m - 1 products. One item is taken at a time; the input stalls until the result has been
// transferred, and the digit-serial multiplier (8 bits a cycle) sets the rate. Reset is
// synchronous and active low; it idles the sequencer and sets the reduction polynomial low
// terms to x^5 + x^2 + x + 1.
module gf2m_field_alu #(
  parameter int FIELD_DEGREE = gfalu_pkg::FIELD_DEGREE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [gfalu_pkg::LOW_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_opcode,
  input  logic [gfalu_pkg::LOW_W-1:0]  in_a_low,
  input  logic [gfalu_pkg::HIGH_W-1:0] in_a_high,
  input  logic [gfalu_pkg::LOW_W-1:0]  in_b_low,
  input  logic [gfalu_pkg::HIGH_W-1:0] in_b_high,
  input  logic [gfalu_pkg::CNT_W-1:0]  in_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gfalu_pkg::LOW_W-1:0]  out_r_low,
  output logic [gfalu_pkg::HIGH_W-1:0] out_r_high,
  output logic                         out_error
);
  import gfalu_pkg::*;

  localparam int M     = FIELD_DEGREE;
  // Width of the squaring count and of the inverse loop index.
  localparam int KW    = $clog2(M + 1);
  // The count is reduced mod m by a reciprocal multiplication: the quotient is
  // (count * RECIP) >> QSH, exact for every count of CNT_W bits since 2^KW > m.
  localparam int QSH   = CNT_W + KW;
  localparam int RECIP = ((1 << QSH) + M - 1) / M;
  localparam int PW    = CNT_W + QSH;
  localparam int EXT_W = M + HIGH_W;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [M-1:0]     a_r, a_nxt;
  logic [M-1:0]     res_r, res_nxt;
  logic             err_r, err_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [KW-1:0]    iter_r, iter_nxt;
  // For inversion: low means the product under way is a square, high a multiply by a.
  logic             phase_r, phase_nxt;
  logic [LOW_W-1:0] poly_r;

  logic [M-1:0]     a_in, b_in;
  logic [EXT_W-1:0] a_ext, b_ext, res_ext;
  mul_ctl_t         mctl;
  mul_sts_t         msts;
  logic [M-1:0]     mul_x, mul_y, mul_p;

  // Operand bits at position m and above are dropped here.
  assign a_ext = {{(M-LOW_W){1'b0}}, in_a_high, in_a_low};
  assign b_ext = {{(M-LOW_W){1'b0}}, in_b_high, in_b_low};
  assign a_in  = a_ext[M-1:0];
  assign b_in  = b_ext[M-1:0];

  gfalu_mul #(.FIELD_DEGREE(M)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mctl),
    .sts    (msts),
    .op_x   (mul_x),
    .op_y   (mul_y),
    .poly   (poly_r),
    .product(mul_p)
  );

  always_comb begin
    logic [PW-1:0]    prod_v;
    logic [CNT_W-1:0] q_v;
    logic [CNT_W-1:0] rem_new;
    logic [KW-1:0]    k_v;
    state_nxt  = state_r;
    op_nxt     = op_r;
    a_nxt      = a_r;
    res_nxt    = res_r;
    err_nxt    = err_r;
    rem_nxt    = rem_r;
    iter_nxt   = iter_r;
    phase_nxt  = phase_r;
    mctl.start = 1'b0;
    mul_x      = mul_p;
    mul_y      = mul_p;
    prod_v     = PW'(rem_r) * PW'(RECIP);
    q_v        = CNT_W'(prod_v >> QSH);
    rem_new    = rem_r - q_v * CNT_W'(M);
    k_v        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt  = op_t'(in_opcode);
          a_nxt   = a_in;
          err_nxt = 1'b0;
          case (op_t'(in_opcode))
            OP_ADD: begin
              res_nxt   = a_in ^ b_in;
              state_nxt = ST_OUT;
            end
            OP_MUL: begin
              mctl.start = 1'b1;
              mul_x      = a_in;
              mul_y      = b_in;
              state_nxt  = ST_MUL;
            end
            OP_SQR: begin
              mctl.start = 1'b1;
              mul_x      = a_in;
              mul_y      = a_in;
              state_nxt  = ST_MUL;
            end
            OP_POW, OP_ROOT: begin
              rem_nxt   = in_count;
              state_nxt = ST_MOD;
            end
            OP_INV: begin
              if (a_in == '0) begin
                res_nxt   = '0;
                err_nxt   = 1'b1;
                state_nxt = ST_OUT;
              end else begin
                // The running power starts at one, so its first square is one.
                mctl.start = 1'b1;
                mul_x      = M'(1);
                mul_y      = M'(1);
                iter_nxt   = KW'(M - 1);
                phase_nxt  = 1'b0;
                state_nxt  = ST_MUL;
              end
            end
            default: begin
              res_nxt   = '0;
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_MOD: begin
        // The count minus m times its quotient is the count mod m.
        rem_nxt = rem_new;
        if (op_r == OP_POW) begin
          k_v = rem_new[KW-1:0];
        end else if (rem_new == '0) begin
          k_v = '0;
        end else begin
          k_v = KW'(M) - rem_new[KW-1:0];
        end
        if (k_v == '0) begin
          res_nxt   = a_r;
          state_nxt = ST_OUT;
        end else begin
          iter_nxt   = k_v;
          mctl.start = 1'b1;
          mul_x      = a_r;
          mul_y      = a_r;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        if (msts.done) begin
          case (op_r)
            OP_POW, OP_ROOT: begin
              if (iter_r == KW'(1)) begin
                res_nxt   = mul_p;
                state_nxt = ST_OUT;
              end else begin
                iter_nxt   = iter_r - 1'b1;
                mctl.start = 1'b1;
              end
            end
            OP_INV: begin
              if (!phase_r && iter_r != '0) begin
                phase_nxt  = 1'b1;
                mctl.start = 1'b1;
                mul_y      = a_r;
              end else if (!phase_r) begin
                res_nxt   = mul_p;
                state_nxt = ST_OUT;
              end else begin
                phase_nxt  = 1'b0;
                iter_nxt   = iter_r - 1'b1;
                mctl.start = 1'b1;
              end
            end
            default: begin
              res_nxt   = mul_p;
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    res_r   <= res_nxt;
    err_r   <= err_nxt;
    rem_r   <= rem_nxt;
    iter_r  <= iter_nxt;
    phase_r <= phase_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= LOW_W'(39);
    end else if (cfg_wr_en) begin
      poly_r <= cfg_wr_data;
    end
  end

  // The result register holds steady for the whole transfer on the output side.
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = (state_r == ST_OUT);
  assign res_ext    = {{HIGH_W{1'b0}}, res_r};
  assign out_r_low  = res_ext[LOW_W-1:0];
  assign out_r_high = res_ext[LOW_W+HIGH_W-1:LOW_W];
  assign out_error  = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_r_low == '0 && out_r_high == '0)
    else $error("error flagged with nonzero result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE)
    else $error("accepted item was dropped");

  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    msts.done |-> state_r == ST_MUL)
    else $error("product ready outside multiply state");

endmodule
